### hw/rtl/mqsb_pkg.sv
`default_nettype none

package mqsb_pkg;

    localparam int QID_W  = 2;
    localparam int WORD_W = 32;

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [QID_W-1:0]   queue_id;
        logic [WORD_W-1:0]  data_in;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  data_out;
        status_t            status;
    } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/mqsb_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/multi_queue_shared_buffer.sv
`default_nettype none

// Several FIFO queues sharing one store of CAPACITY slots. Each req transfer
// either enqueues data_in onto queue queue_id or dequeues that queue's oldest
// word; every req transfer yields exactly one rsp transfer, in order. status
// is ST_OK, ST_OVERFLOW (enqueue with no free slot or a queue number at or
// above NUM_QUEUES) or ST_UNDERFLOW (dequeue of an empty or nonexistent
// queue); failed operations change nothing and return data_out zero, as does
// every enqueue. Words are cut to DATA_WIDTH bits when stored. Throughput is
// one transfer per clock: the slot RAMs are addressed at the req transfer
// from the state as it will stand after the item ahead, the item executes in
// the following cycle (link and word RAM read data plus a one-entry write
// bypass), and its result lands in a two-entry output buffer, from which the
// response is presented on rsp. The output buffer lets one more req transfer
// in while a result waits on rsp_ready; with one result waiting and another
// in execute, req_ready stays low until rsp drains. There is no clearing
// pass after reset: a fill counter tracks the slots never handed out, whose
// free-list links are implied rather than stored.
module multi_queue_shared_buffer #(
    parameter int CAPACITY   = 16,
    parameter int NUM_QUEUES = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mqsb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mqsb_pkg::rsp_t rsp
);

    import mqsb_pkg::*;

    // slot numbers carry one extra code: CAPACITY means null
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    // only 2**QID_W queues are addressable through queue_id
    localparam int QD  = (NUM_QUEUES < (1 << QID_W)) ? NUM_QUEUES : (1 << QID_W);
    localparam int QIW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
    localparam logic [SW-1:0] NIL = SW'(CAPACITY);

    // queue tables and free list
    logic [SW-1:0] head_reg [QD];
    logic [SW-1:0] head_next [QD];
    logic [SW-1:0] tail_reg [QD];
    logic [SW-1:0] tail_next [QD];
    logic [SW-1:0] free_head_reg, free_head_next;
    // slots below this count have been handed out at least once
    logic [SW-1:0] fresh_reg, fresh_next;

    // execute stage
    logic          e_vld_reg;
    req_t          e_item_reg;
    rsp_t          e_rsp;

    // slot RAM ports
    logic                  link_we, link_re;
    logic [AW-1:0]         link_waddr, link_raddr;
    logic [SW-1:0]         link_wdata, link_rdata;
    logic                  word_we;
    logic [AW-1:0]         word_waddr, word_raddr;
    logic [DATA_WIDTH-1:0] word_wdata, word_rdata;

    // last-cycle writes, forwarded to a read issued at the same edge
    logic                  lb_vld_reg;
    logic [AW-1:0]         lb_addr_reg;
    logic [SW-1:0]         lb_data_reg;
    logic                  wb_vld_reg;
    logic [AW-1:0]         wb_addr_reg;
    logic [DATA_WIDTH-1:0] wb_data_reg;

    // output buffer
    rsp_t       obuf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       accept, push, pop;

    assign accept = req_valid && req_ready;
    assign push   = e_vld_reg;
    assign pop    = rsp_valid && rsp_ready;

    //------------------------------------------------------------------
    // Execute: one item's full update from registered state and RAM data
    //------------------------------------------------------------------
    always_comb
    begin
        logic [QIW-1:0]        qi;
        logic                  q_ok;
        logic [SW-1:0]         s;
        logic [SW-1:0]         h;
        logic [SW-1:0]         lnk;
        logic [DATA_WIDTH-1:0] wrd;

        qi   = e_item_reg.queue_id[QIW-1:0];
        q_ok = (32'(e_item_reg.queue_id) < NUM_QUEUES);
        s    = free_head_reg;
        h    = head_reg[qi];
        wrd  = (wb_vld_reg && wb_addr_reg == h[AW-1:0]) ? wb_data_reg : word_rdata;

        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        lnk            = NIL;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        word_we    = 1'b0;
        word_waddr = s[AW-1:0];
        word_wdata = '0;
        word_wdata[CW-1:0] = e_item_reg.data_in[CW-1:0];

        e_rsp.data_out = '0;
        e_rsp.status   = ST_OK;

        if (e_vld_reg)
        begin
            case (e_item_reg.cmd)
                CMD_ENQ:
                begin
                    if (!q_ok || s >= NIL)
                    begin
                        e_rsp.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        // a never-used slot implicitly links to its successor
                        if (s == fresh_reg)
                        begin
                            lnk        = s + SW'(1);
                            fresh_next = fresh_reg + SW'(1);
                        end
                        else if (lb_vld_reg && lb_addr_reg == s[AW-1:0])
                        begin
                            lnk = lb_data_reg;
                        end
                        else
                        begin
                            lnk = link_rdata;
                        end
                        free_head_next = lnk;
                        if (head_reg[qi] >= NIL)
                        begin
                            head_next[qi] = s;
                        end
                        else if (tail_reg[qi] < NIL)
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg[qi][AW-1:0];
                            link_wdata = s;
                        end
                        // the tail's own link is left stale; dequeue checks
                        // head against tail instead
                        tail_next[qi] = s;
                        word_we       = 1'b1;
                    end
                end
                CMD_DEQ:
                begin
                    if (!q_ok || h >= NIL)
                    begin
                        e_rsp.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        if (h == tail_reg[qi])
                        begin
                            lnk = NIL;
                        end
                        else if (lb_vld_reg && lb_addr_reg == h[AW-1:0])
                        begin
                            lnk = lb_data_reg;
                        end
                        else
                        begin
                            lnk = link_rdata;
                        end
                        head_next[qi]  = lnk;
                        link_we        = 1'b1;
                        link_waddr     = h[AW-1:0];
                        link_wdata     = free_head_reg;
                        free_head_next = h;
                        e_rsp.data_out[CW-1:0] = wrd[CW-1:0];
                    end
                end
                default:
                begin
                    e_rsp.status = ST_OK;
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // Read addresses for the incoming item, taken from next-state values
    //------------------------------------------------------------------
    always_comb
    begin
        logic [QIW-1:0] rq;
        logic [SW-1:0]  hq;

        rq = req.queue_id[QIW-1:0];
        hq = head_next[rq];
        link_re    = accept;
        link_raddr = (req.cmd == CMD_ENQ) ? free_head_next[AW-1:0] : hq[AW-1:0];
        word_raddr = hq[AW-1:0];
    end

    mqsb_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .re    (link_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    //------------------------------------------------------------------
    // Output buffer, two entries: one being drained, one landing
    //------------------------------------------------------------------
    assign rsp_valid = (ocnt_reg != 2'd0);
    assign rsp       = obuf_reg[rd_ptr_reg];
    // room counts the item in execute; a transfer on rsp frees a place
    assign req_ready = ((ocnt_reg + {1'b0, e_vld_reg}) != 2'd2) || pop;
    assign ocnt_next = 2'(ocnt_reg + {1'b0, push} - {1'b0, pop});

    //------------------------------------------------------------------
    // Registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QD; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            free_head_reg <= '0;
            fresh_reg     <= '0;
            e_vld_reg     <= 1'b0;
            lb_vld_reg    <= 1'b0;
            wb_vld_reg    <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            ocnt_reg      <= 2'd0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            e_vld_reg     <= accept;
            lb_vld_reg    <= link_we;
            wb_vld_reg    <= word_we;
            ocnt_reg      <= ocnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_item_reg <= req;
        end
        lb_addr_reg <= link_waddr;
        lb_data_reg <= link_wdata;
        wb_addr_reg <= word_waddr;
        wb_data_reg <= word_wdata;
        if (push)
        begin
            obuf_reg[wr_ptr_reg] <= e_rsp;
        end
    end

endmodule

`default_nettype wire

### tb/multi_queue_shared_buffer_tb.sv
`timescale 1ns / 100ps

module multi_queue_shared_buffer_tb;

    import mqsb_pkg::*;

    localparam int SLOTS       = 16;
    localparam int QUEUES      = 4;
    localparam logic [4:0] NULL_SLOT = 5'(SLOTS);
    localparam int HOLD_CYCLES = 120;      // long rsp back-pressure stretch
    localparam int DRAIN_TAIL  = 20;       // quiet tail after draining, to catch stray responses
    localparam int TIMEOUT_NS  = 2_000_000;
    localparam int BURST_LEN   = 40;

    // one directed stimulus row; want is only meaningful when typed is set
    typedef struct {
        req_t  item;
        bit    typed;
        rsp_t  want;
    } op_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_bus;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp_bus;

    // typed expectation riding along with the item on the req side
    bit   row_typed;
    rsp_t row_want;

    // handshake pacing, set per phase by the stimulus
    int send_idle_pct;
    int rsp_stall_pct;
    int hold_trigger;

    int   mismatches;
    rsp_t expected_rsp_q[$];

    // shadow of the linked slot store
    logic [4:0]  head_slot [QUEUES];
    logic [4:0]  tail_slot [QUEUES];
    logic [4:0]  next_slot [SLOTS];
    logic [31:0] slot_data [SLOTS];
    logic [4:0]  free_slot;

    op_row_t directed_rows[$];

    multi_queue_shared_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_bus),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_bus)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one operation to the shadow store and returns its response.
    // A drained queue keeps a stale tail; it is only consulted once head is set.
    function automatic rsp_t apply_queue_op(input req_t item);
        rsp_t       r;
        logic [4:0] s;
        int         q;
        r.data_out = '0;
        r.status   = ST_OK;
        q          = int'(item.queue_id);
        if (item.cmd == CMD_ENQ) begin
            s = free_slot;
            if (q >= QUEUES || s >= NULL_SLOT) begin
                r.status = ST_OVERFLOW;
            end
            else begin
                free_slot = next_slot[s[3:0]];
                if (head_slot[q] >= NULL_SLOT)
                    head_slot[q] = s;
                else if (tail_slot[q] < NULL_SLOT)
                    next_slot[tail_slot[q][3:0]] = s;
                next_slot[s[3:0]] = NULL_SLOT;
                tail_slot[q] = s;
                slot_data[s[3:0]] = item.data_in;
            end
        end
        else begin
            if (q >= QUEUES || head_slot[q] >= NULL_SLOT) begin
                r.status = ST_UNDERFLOW;
            end
            else begin
                s                 = head_slot[q];
                head_slot[q]      = next_slot[s[3:0]];
                next_slot[s[3:0]] = free_slot;
                free_slot         = s;
                r.data_out        = slot_data[s[3:0]];
            end
        end
        return r;
    endfunction

    function automatic op_row_t mk_row(input cmd_t c, input int q, input logic [31:0] d,
                                       input bit typed, input status_t st,
                                       input logic [31:0] dout);
        op_row_t row;
        row.item.cmd      = c;
        row.item.queue_id = QID_W'(q);
        row.item.data_in  = d;
        row.typed         = typed;
        row.want.data_out = dout;
        row.want.status   = st;
        return row;
    endfunction

    // Offer one item; valid stays up until the transfer, and is only dropped
    // for an idle gap before the next one.
    task automatic send_op(input req_t item, input bit typed, input rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= item;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random traffic in bursts: each burst picks an enqueue bias (fill up to
    // overflow, drain down to underflow, or balanced) and may favor one queue.
    task automatic send_random(input int count);
        req_t item;
        rsp_t none;
        int   enq_bias;
        int   focus_q;
        bit   focused;
        none     = '0;
        enq_bias = 50;
        focus_q  = 0;
        focused  = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % BURST_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_bias = 80;
                    1:       enq_bias = 20;
                    default: enq_bias = 55;
                endcase
                focus_q = $urandom_range(0, QUEUES - 1);
                focused = 1'($urandom_range(0, 1));
            end
            item.cmd = ($urandom_range(0, 99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
            if (focused && $urandom_range(0, 3) != 0)
                item.queue_id = QID_W'(focus_q);
            else
                item.queue_id = QID_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       item.data_in = '0;
                1:       item.data_in = '1;
                default: item.data_in = $urandom;
            endcase
            send_op(item, 1'b0, none);
        end
    endtask

    task automatic wait_drained();
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
    endtask

    // Transfer monitor: predicts at each req transfer, checks each rsp
    // transfer against the oldest expectation. Both sampled at the rising edge.
    always @(posedge clk) begin : xfer_monitor
        rsp_t predicted;
        rsp_t want;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                predicted = apply_queue_op(req_bus);
                expected_rsp_q.push_back(row_typed ? row_want : predicted);
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected rsp data_out=%h status=%0d",
                                              rsp_bus.data_out, rsp_bus.status));
                end
                else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_bus.data_out !== want.data_out)
                        report_mismatch($sformatf("data_out got %h want %h",
                                                  rsp_bus.data_out, want.data_out));
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_bus.status, want.status));
                end
            end
        end
    end

    // Response side: random stalls, plus a long hold-off counted here
    // whenever the stimulus bumps hold_trigger.
    initial begin : rsp_side
        int hold_left;
        int hold_taken;
        hold_left  = 0;
        hold_taken = 0;
        rsp_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_trigger != hold_taken) begin
                hold_taken = hold_trigger;
                hold_left  = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        op_row_t row;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_bus       = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_trigger  = 0;
        mismatches    = 0;

        // shadow store in its reset state: queues empty, free list 0..15
        free_slot = '0;
        for (int i = 0; i < QUEUES; i++) begin
            head_slot[i] = NULL_SLOT;
            tail_slot[i] = NULL_SLOT;
        end
        for (int i = 0; i < SLOTS; i++) begin
            next_slot[i] = 5'(i + 1);
            slot_data[i] = '0;
        end

        // directed rows: empty queues, extreme words, stale tail after
        // draining, a full store, then dequeues out of the full store
        directed_rows.push_back(mk_row(CMD_DEQ, 0, 32'h0, 1, ST_UNDERFLOW, 32'h0));
        directed_rows.push_back(mk_row(CMD_DEQ, 3, 32'hFFFF_FFFF, 1, ST_UNDERFLOW, 32'h0));
        directed_rows.push_back(mk_row(CMD_ENQ, 0, 32'h0, 1, ST_OK, 32'h0));
        directed_rows.push_back(mk_row(CMD_ENQ, 3, 32'hFFFF_FFFF, 1, ST_OK, 32'h0));
        directed_rows.push_back(mk_row(CMD_DEQ, 3, 32'h0, 1, ST_OK, 32'hFFFF_FFFF));
        directed_rows.push_back(mk_row(CMD_DEQ, 3, 32'h0, 1, ST_UNDERFLOW, 32'h0));
        directed_rows.push_back(mk_row(CMD_ENQ, 3, 32'hA5A5_A5A5, 0, ST_OK, 32'h0));
        directed_rows.push_back(mk_row(CMD_DEQ, 0, 32'h0, 1, ST_OK, 32'h0));
        for (int i = 0; i < SLOTS - 1; i++)
            directed_rows.push_back(mk_row(CMD_ENQ, 1 + i % 2, 32'h0101_0101 * i,
                                           0, ST_OK, 32'h0));
        directed_rows.push_back(mk_row(CMD_ENQ, 2, 32'h5A5A_5A5A, 1, ST_OVERFLOW, 32'h0));
        directed_rows.push_back(mk_row(CMD_DEQ, 1, 32'h0, 0, ST_OK, 32'h0));
        directed_rows.push_back(mk_row(CMD_DEQ, 3, 32'h0, 0, ST_OK, 32'h0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_op(row.item, row.typed, row.want);
        end

        // phase 1: no idling, opened by a long rsp hold-off so req backs up
        hold_trigger++;
        send_random(310);

        // phase 2: sender idles often, then pauses until everything is back
        send_idle_pct = 47;
        rsp_stall_pct = 0;
        send_random(310);
        req_valid <= 1'b0;
        wait_drained();

        // phase 3: receiver stalls often
        send_idle_pct = 0;
        rsp_stall_pct = 47;
        send_random(310);

        // phase 4: both sides idle, with a second long hold-off
        send_idle_pct = 36;
        rsp_stall_pct = 36;
        hold_trigger++;
        send_random(310);

        req_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_TAIL) @(negedge clk);

        if (expected_rsp_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsp_q.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
